@@ rtl/hex_text_to_integer_top_macros.svh @@
// Assertion macros for the hex text parser.
`ifndef HEX_TEXT_TO_INTEGER_TOP_MACROS_SVH
`define HEX_TEXT_TO_INTEGER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define HTTI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("htti: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define HTTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("htti: next-cycle check failed");

`endif

@@ rtl/htti_pkg.sv @@
`timescale 1ns / 1ps

package htti_pkg;

    localparam int CHAR_W   = 8;
    localparam int MAXC_W   = 16;
    localparam int SIZE_W   = 2;
    localparam int VALUE_W  = 64;
    localparam int DIGIT_W  = 4;
    localparam int PHASE_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_16 = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_32 = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_64 = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_XCHK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_BASE = 8'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              start_req;
        logic [MAXC_W-1:0] max_chars;
        logic [SIZE_W-1:0] value_size;
        logic              skip_store;
    } t_in_item;

    typedef struct packed {
        logic                      consumed;
        logic                      done_res;
        logic                      success;
        logic signed [VALUE_W-1:0] parsed_value;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [VALUE_W-1:0] accumulator;
        logic               minus_seen;
        logic               leading_zero_seen;
        logic [SIZE_W-1:0]  size_mode;
        logic               store_suppressed;
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    function automatic logic [VALUE_W-1:0] size_mask(input logic [SIZE_W-1:0] mode);
        logic [VALUE_W-1:0] m;
        unique case (mode)
            SIZE_16: m = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
            SIZE_32: m = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
            default: m = {VALUE_W{1'b1}};
        endcase
        return m;
    endfunction

    function automatic logic [VALUE_W-1:0] sext(input logic [VALUE_W-1:0] v,
                                                input logic [SIZE_W-1:0]  mode);
        logic [VALUE_W-1:0] r;
        unique case (mode)
            SIZE_16: r = {{(VALUE_W-16){v[15]}}, v[15:0]};
            SIZE_32: r = {{(VALUE_W-32){v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic signed_less(input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b,
                                         input logic [SIZE_W-1:0]  mode);
        return $signed(sext(a, mode)) < $signed(sext(b, mode));
    endfunction

    function automatic t_digit hex_digit(input logic [CHAR_W-1:0] c);
        t_digit            d;
        logic [CHAR_W-1:0] t;
        d = '0;
        t = '0;
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
            d.valid = 1'b1;
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            t = c - CH_A_LO + HEX_ALPHA_BASE;
            d.valid = 1'b1;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            t = c - CH_A_UP + HEX_ALPHA_BASE;
            d.valid = 1'b1;
        end
        d.value = t[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

@@ rtl/htti_in_if.sv @@
`timescale 1ns / 1ps

interface htti_in_if;
    logic                          valid;
    logic                          ready;
    logic [htti_pkg::CHAR_W-1:0]   char_code;
    logic                          start_req;
    logic [htti_pkg::MAXC_W-1:0]   max_chars;
    logic [htti_pkg::SIZE_W-1:0]   value_size;
    logic                          skip_store;

    modport source (output valid, char_code, start_req, max_chars, value_size, skip_store,
                    input ready);
    modport sink   (input valid, char_code, start_req, max_chars, value_size, skip_store,
                    output ready);
endinterface

@@ rtl/htti_out_if.sv @@
`timescale 1ns / 1ps

interface htti_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 consumed;
    logic                                 done_res;
    logic                                 success;
    logic signed [htti_pkg::VALUE_W-1:0]  parsed_value;

    modport source (output valid, consumed, done_res, success, parsed_value, input ready);
    modport sink   (input valid, consumed, done_res, success, parsed_value, output ready);
endinterface

@@ rtl/htti_step.sv @@
`timescale 1ns / 1ps

module htti_step #(
    parameter int COUNT_BITS = 16
) (
    input  htti_pkg::t_in_item      i_item,
    input  htti_pkg::t_state        i_state,
    input  logic [COUNT_BITS-1:0]   i_count,
    output htti_pkg::t_state        o_state,
    output logic [COUNT_BITS-1:0]   o_count,
    output htti_pkg::t_result       o_result
);

    htti_pkg::t_digit                        w_dig;
    logic [htti_pkg::VALUE_W-1:0]            w_mask_cur;
    logic [htti_pkg::VALUE_W-1:0]            w_next;
    logic                                    w_ovf;
    logic                                    w_stop;
    logic                                    w_take;
    logic                                    w_fin;
    logic [htti_pkg::PHASE_W-1:0]            w_nph;
    logic [htti_pkg::VALUE_W-1:0]            w_mask;
    logic [htti_pkg::VALUE_W-1:0]            w_v;
    logic                                    w_ok;
    logic [htti_pkg::CHAR_W-1:0]             w_c;

    assign w_c        = i_item.char_code;
    assign w_dig      = htti_pkg::hex_digit(w_c);
    assign w_mask_cur = htti_pkg::size_mask(i_state.size_mode);
    assign w_next     = ((i_state.accumulator << htti_pkg::DIGIT_W)
                        + {{(htti_pkg::VALUE_W-htti_pkg::DIGIT_W){1'b0}}, w_dig.value})
                        & w_mask_cur;
    assign w_ovf      = htti_pkg::signed_less(w_next, i_state.accumulator, i_state.size_mode);

    always_comb begin
        o_state  = i_state;
        o_count  = i_count;
        o_result = '0;
        w_stop   = 1'b0;
        w_take   = 1'b0;
        w_fin    = 1'b0;
        w_nph    = o_state.phase;
        w_mask   = '0;
        w_v      = '0;
        w_ok     = 1'b0;

        if (i_item.start_req) begin
            o_state.phase             = htti_pkg::PH_SIGN;
            o_state.accumulator       = '0;
            o_state.minus_seen        = 1'b0;
            o_state.leading_zero_seen = 1'b0;
            o_count                   = COUNT_BITS'(i_item.max_chars);
            o_state.size_mode         = (i_item.value_size > htti_pkg::SIZE_64) ?
                                        htti_pkg::SIZE_64 : i_item.value_size;
            o_state.store_suppressed  = i_item.skip_store;
            if (o_count == '0) begin
                w_fin  = 1'b1;
                w_stop = 1'b1;
            end
        end

        if (!w_stop && o_state.phase == htti_pkg::PH_IDLE) begin
            w_stop = 1'b1;
        end

        if (!w_stop && o_state.phase == htti_pkg::PH_SIGN) begin
            if (w_c == htti_pkg::CH_PLUS || w_c == htti_pkg::CH_MINUS) begin
                o_state.minus_seen = (w_c == htti_pkg::CH_MINUS);
                w_take = 1'b1;
                w_nph  = htti_pkg::PH_ZERO;
                w_stop = 1'b1;
            end else begin
                o_state.phase = htti_pkg::PH_ZERO;
            end
        end

        if (!w_stop && o_state.phase == htti_pkg::PH_ZERO) begin
            if (w_c == htti_pkg::CH_0) begin
                o_state.leading_zero_seen = 1'b1;
                w_take = 1'b1;
                w_nph  = htti_pkg::PH_XCHK;
                w_stop = 1'b1;
            end else begin
                o_state.phase = htti_pkg::PH_FIRST;
            end
        end

        if (!w_stop && o_state.phase == htti_pkg::PH_XCHK) begin
            if (w_c == htti_pkg::CH_X_LO || w_c == htti_pkg::CH_X_UP) begin
                w_take = 1'b1;
                w_nph  = htti_pkg::PH_FIRST;
                w_stop = 1'b1;
            end else if (!w_dig.valid) begin
                w_fin  = 1'b1;
                w_stop = 1'b1;
            end else begin
                o_state.phase = htti_pkg::PH_FIRST;
            end
        end

        if (!w_stop && o_state.phase == htti_pkg::PH_FIRST) begin
            if (!w_dig.valid) begin
                w_fin = 1'b1;
            end else begin
                o_state.accumulator = {{(htti_pkg::VALUE_W-htti_pkg::DIGIT_W){1'b0}},
                                       w_dig.value};
                w_take = 1'b1;
                w_nph  = htti_pkg::PH_DIGITS;
            end
            w_stop = 1'b1;
        end

        if (!w_stop) begin
            if (!w_dig.valid) begin
                w_fin = 1'b1;
            end else if (w_ovf) begin
                o_state.accumulator = w_mask_cur;
                o_result.consumed   = 1'b1;
                w_fin = 1'b1;
            end else begin
                o_state.accumulator = w_next;
                w_take = 1'b1;
                w_nph  = htti_pkg::PH_DIGITS;
            end
        end

        if (w_take) begin
            o_result.consumed = 1'b1;
            o_count = o_count - COUNT_BITS'(1);
            if (o_count == '0) begin
                w_fin = 1'b1;
            end else begin
                o_state.phase = w_nph;
            end
        end

        if (w_fin) begin
            w_mask = htti_pkg::size_mask(o_state.size_mode);
            w_v    = o_state.accumulator & w_mask;
            w_ok   = (w_v != '0) || o_state.leading_zero_seen;
            if (o_state.minus_seen) begin
                w_v = (-w_v) & w_mask;
            end
            o_result.done_res     = 1'b1;
            o_result.success      = w_ok && !o_state.store_suppressed;
            o_result.parsed_value = $signed(htti_pkg::sext(w_v, o_state.size_mode));
            o_state.phase         = htti_pkg::PH_IDLE;
        end
    end

endmodule

@@ rtl/hex_text_to_integer_top.sv @@
// Hex text to integer: parses one scanf-style hex conversion from a stream of characters,
// one character per transfer, giving one result per character (consumed, done, success and
// the signed value sign-extended from 16, 32 or 64 bits). Sustained rate is one character
// per clock while the output is taken; each character passes the input register, then the
// result register. The per-character state update (shift-add of the accumulator, signed
// overflow compare, final negate and sign extension) is combinational between those
// registers. While a result waits at the output, the input register holds at most one
// further character, and once it holds one, ready stays low until the result is taken.
`timescale 1ns / 1ps
`include "hex_text_to_integer_top_macros.svh"

module hex_text_to_integer_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    htti_in_if.sink           i_in_ch,
    htti_out_if.source        o_out_ch
);

    logic                       r_in_valid;
    htti_pkg::t_in_item         r_in;
    htti_pkg::t_state           r_state;
    logic [COUNT_BITS-1:0]      r_count;
    logic                       r_out_valid;
    htti_pkg::t_result          r_out;

    htti_pkg::t_state           n_state;
    logic [COUNT_BITS-1:0]      n_count;
    htti_pkg::t_result          n_result;

    logic                       w_fire;
    logic                       w_in_xfer;

    assign w_fire        = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || w_fire;
    assign w_in_xfer     = i_in_ch.valid && i_in_ch.ready;

    htti_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_count  (r_count),
        .o_state  (n_state),
        .o_count  (n_count),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_count     <= '0;
        end else begin
            if (i_in_ch.ready) begin
                r_in_valid <= i_in_ch.valid;
            end
            if (w_fire) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.char_code  <= i_in_ch.char_code;
            r_in.start_req  <= i_in_ch.start_req;
            r_in.max_chars  <= i_in_ch.max_chars;
            r_in.value_size <= i_in_ch.value_size;
            r_in.skip_store <= i_in_ch.skip_store;
        end
        if (w_fire) begin
            r_out <= n_result;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.consumed     = r_out.consumed;
    assign o_out_ch.done_res     = r_out.done_res;
    assign o_out_ch.success      = r_out.success;
    assign o_out_ch.parsed_value = r_out.parsed_value;

    `HTTI_ASSERT_SAME(a_idle_result_zero, r_out_valid && !r_out.done_res, !r_out.success && r_out.parsed_value == '0)
    `HTTI_ASSERT_NEXT(a_done_goes_idle, w_fire && n_result.done_res, r_state.phase == htti_pkg::PH_IDLE)
    `HTTI_ASSERT_SAME(a_busy_has_count, r_state.phase != htti_pkg::PH_IDLE, r_count != '0)
    `HTTI_ASSERT_SAME(a_ready_when_out_free, !r_out_valid, i_in_ch.ready)

endmodule

@@ bench/hex_text_to_integer_top_tb.sv @@
`timescale 1ns / 1ps

module hex_text_to_integer_top_tb;
    import htti_pkg::*;

    localparam int CNT_W       = 16;
    localparam int RAND_ITEMS  = 500;
    localparam int DRAIN_EVERY = 150;
    localparam logic [SIZE_W-1:0] SIZE_CODE_3 = 2'd3;

    typedef struct packed {
        logic    typed;
        t_result want;
    } t_note;

    typedef struct packed {
        t_in_item it;
        logic     typed;
        t_result  want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    htti_in_if  in_ch ();
    htti_out_if out_ch ();

    hex_text_to_integer_top #(
        .COUNT_BITS(CNT_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser model state
    logic [PHASE_W-1:0] ph_q;
    logic [VALUE_W-1:0] acc_q;
    logic               minus_q;
    logic               lz_q;
    logic [CNT_W-1:0]   rem_q;
    logic [SIZE_W-1:0]  mode_q;
    logic               supp_q;

    t_note    note_q [$];
    t_result  result_q [$];
    t_dir_row dir_tab [0:24];
    int       err_cnt    = 0;
    int       items_sent = 0;
    logic     no_idle    = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_digit hex_of(input logic [CHAR_W-1:0] c);
        t_digit d;
        d = '0;
        if (c inside {[CH_0:CH_9]}) begin
            d.valid = 1'b1;
            d.value = DIGIT_W'(c - CH_0);
        end else if (c inside {[CH_A_LO:CH_F_LO]}) begin
            d.valid = 1'b1;
            d.value = DIGIT_W'(c - CH_A_LO + 8'd10);
        end else if (c inside {[CH_A_UP:CH_F_UP]}) begin
            d.valid = 1'b1;
            d.value = DIGIT_W'(c - CH_A_UP + 8'd10);
        end
        return d;
    endfunction

    function automatic int width_of(input logic [SIZE_W-1:0] mode);
        case (mode)
            SIZE_16: return 16;
            SIZE_32: return 32;
            default: return 64;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] mask_of(input logic [SIZE_W-1:0] mode);
        int w;
        w = width_of(mode);
        return (w == 64) ? {VALUE_W{1'b1}} : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [VALUE_W-1:0] sign_ext(input logic [VALUE_W-1:0] v,
                                                    input logic [SIZE_W-1:0]  mode);
        logic signed [VALUE_W-1:0] t;
        int                        sh;
        sh = 64 - width_of(mode);
        t  = v << sh;
        return t >>> sh;
    endfunction

    task automatic close_conv(inout t_result r);
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] v;
        logic               ok;
        m  = mask_of(mode_q);
        v  = acc_q & m;
        ok = (v != '0) || lz_q;
        if (minus_q) v = (~v + 64'd1) & m;
        r.done_res     = 1'b1;
        r.success      = ok && !supp_q;
        r.parsed_value = sign_ext(v, mode_q);
        ph_q           = PH_IDLE;
    endtask

    task automatic take_char(inout t_result r, output logic closed);
        r.consumed = 1'b1;
        rem_q      = rem_q - CNT_W'(1);
        closed     = (rem_q == '0);
        if (closed) close_conv(r);
    endtask

    task automatic predict_char(input t_in_item it, output t_result r);
        t_digit             d;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] nxt;
        logic               fin;
        logic               closed;
        logic [CHAR_W-1:0]  c;
        c   = it.char_code;
        d   = hex_of(c);
        r   = '0;
        fin = 1'b0;
        if (it.start_req) begin
            ph_q    = PH_SIGN;
            acc_q   = '0;
            minus_q = 1'b0;
            lz_q    = 1'b0;
            rem_q   = it.max_chars;
            mode_q  = (it.value_size > SIZE_64) ? SIZE_64 : it.value_size;
            supp_q  = it.skip_store;
            if (rem_q == '0) begin
                close_conv(r);
                fin = 1'b1;
            end
        end
        if (!fin && ph_q == PH_IDLE) fin = 1'b1;
        if (!fin && ph_q == PH_SIGN) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
                minus_q = (c == CH_MINUS);
                take_char(r, closed);
                if (!closed) ph_q = PH_ZERO;
                fin = 1'b1;
            end else begin
                ph_q = PH_ZERO;
            end
        end
        if (!fin && ph_q == PH_ZERO) begin
            if (c == CH_0) begin
                lz_q = 1'b1;
                take_char(r, closed);
                if (!closed) ph_q = PH_XCHK;
                fin = 1'b1;
            end else begin
                ph_q = PH_FIRST;
            end
        end
        if (!fin && ph_q == PH_XCHK) begin
            if (c == CH_X_LO || c == CH_X_UP) begin
                take_char(r, closed);
                if (!closed) ph_q = PH_FIRST;
                fin = 1'b1;
            end else if (!d.valid) begin
                close_conv(r);
                fin = 1'b1;
            end else begin
                ph_q = PH_FIRST;
            end
        end
        if (!fin && ph_q == PH_FIRST) begin
            if (!d.valid) begin
                close_conv(r);
            end else begin
                acc_q = VALUE_W'(d.value);
                take_char(r, closed);
                if (!closed) ph_q = PH_DIGITS;
            end
            fin = 1'b1;
        end
        if (!fin) begin
            if (!d.valid) begin
                close_conv(r);
            end else begin
                m   = mask_of(mode_q);
                nxt = ((acc_q << 4) + VALUE_W'(d.value)) & m;
                // signed drop at the selected size saturates to all ones
                if ($signed(sign_ext(nxt, mode_q)) < $signed(sign_ext(acc_q, mode_q))) begin
                    acc_q      = m;
                    r.consumed = 1'b1;
                    close_conv(r);
                end else begin
                    acc_q = nxt;
                    take_char(r, closed);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : mon_blk
        t_note    nt;
        t_in_item it;
        t_result  pr;
        t_result  got;
        t_result  want;
        if (!i_rst_n) begin
            ph_q    = PH_IDLE;
            acc_q   = '0;
            minus_q = 1'b0;
            lz_q    = 1'b0;
            rem_q   = '0;
            mode_q  = SIZE_16;
            supp_q  = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                nt = '0;
                if (note_q.size() != 0) nt = note_q.pop_front();
                it.char_code  = in_ch.char_code;
                it.start_req  = in_ch.start_req;
                it.max_chars  = in_ch.max_chars;
                it.value_size = in_ch.value_size;
                it.skip_store = in_ch.skip_store;
                predict_char(it, pr);
                result_q.push_back(nt.typed ? nt.want : pr);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.consumed     = out_ch.consumed;
                got.done_res     = out_ch.done_res;
                got.success      = out_ch.success;
                got.parsed_value = out_ch.parsed_value;
                if (result_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = result_q.pop_front();
                    if (got.consumed !== want.consumed)
                        report_mismatch($sformatf("consumed %b, want %b",
                                                  got.consumed, want.consumed));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res %b, want %b",
                                                  got.done_res, want.done_res));
                    if (got.success !== want.success)
                        report_mismatch($sformatf("success %b, want %b",
                                                  got.success, want.success));
                    if (got.parsed_value !== want.parsed_value)
                        report_mismatch($sformatf("parsed_value %h, want %h",
                                                  got.parsed_value, want.parsed_value));
                end
            end
        end
    end

    function automatic t_in_item chr(input logic [CHAR_W-1:0] c, input logic st,
                                     input logic [MAXC_W-1:0] mx,
                                     input logic [SIZE_W-1:0] sz, input logic na);
        t_in_item it;
        it.char_code  = c;
        it.start_req  = st;
        it.max_chars  = mx;
        it.value_size = sz;
        it.skip_store = na;
        return it;
    endfunction

    function automatic t_in_item next_chr(input logic [CHAR_W-1:0] c);
        return chr(c, 1'b0, '0, SIZE_16, 1'b0);
    endfunction

    function automatic t_result res(input logic cons, input logic done, input logic succ,
                                    input logic [VALUE_W-1:0] val);
        t_result r;
        r.consumed     = cons;
        r.done_res     = done;
        r.success      = succ;
        r.parsed_value = val;
        return r;
    endfunction

    function automatic t_dir_row row_pred(input t_in_item it);
        t_dir_row d;
        d.it    = it;
        d.typed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic t_dir_row row_typed(input t_in_item it, input t_result w);
        t_dir_row d;
        d.it    = it;
        d.typed = 1'b1;
        d.want  = w;
        return d;
    endfunction

    task automatic send_char(input t_in_item it, input logic typed, input t_result want);
        int    gap;
        t_note nt;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        nt.typed = typed;
        nt.want  = want;
        note_q.push_back(nt);
        in_ch.valid      <= 1'b1;
        in_ch.char_code  <= it.char_code;
        in_ch.start_req  <= it.start_req;
        in_ch.max_chars  <= it.max_chars;
        in_ch.value_size <= it.value_size;
        in_ch.skip_store <= it.skip_store;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0 || note_q.size() != 0);
    endtask

    task automatic run_conversion();
        logic [CHAR_W-1:0] txt [$];
        t_in_item          it;
        t_digit            hd;
        int                kind;
        int                nd;
        int                r;
        logic [DIGIT_W-1:0] dv;
        logic [CHAR_W-1:0] c;
        logic [MAXC_W-1:0] mx;
        logic [SIZE_W-1:0] sz;
        logic              na;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            nd = $urandom_range(1, 8);
            repeat (nd) txt.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
            r = $urandom_range(0, 3);
            if (r == 0) txt.push_back(CH_PLUS);
            else if (r == 1) txt.push_back(CH_MINUS);
            if ($urandom_range(0, 2) == 0) begin
                txt.push_back(CH_0);
                if ($urandom_range(0, 1) == 1)
                    txt.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            end
            nd = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 8);
            repeat (nd) begin
                dv = DIGIT_W'($urandom_range(0, 15));
                if (dv < 10) c = CH_0 + dv;
                else c = ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + dv - 8'd10;
                txt.push_back(c);
            end
            // without a terminator the next start drops this conversion
            if (kind >= 20) begin
                if ($urandom_range(0, 2) == 0) begin
                    txt.push_back(8'h00);
                end else begin
                    do begin
                        c  = CHAR_W'($urandom_range(0, 255));
                        hd = hex_of(c);
                    end while (hd.valid);
                    txt.push_back(c);
                end
            end
            if (txt.size() == 0) txt.push_back(8'h00);
        end
        r = $urandom_range(0, 99);
        if (r < 30) mx = MAXC_W'($urandom_range(1, txt.size()));
        else if (r < 55) mx = {MAXC_W{1'b1}};
        else if (r < 75) mx = MAXC_W'($urandom_range(0, 20));
        else mx = MAXC_W'($urandom_range(0, 65535));
        sz = SIZE_W'($urandom_range(0, 3));
        na = ($urandom_range(0, 3) == 0);
        foreach (txt[i]) begin
            if (i == 0) begin
                it = chr(txt[i], 1'b1, mx, sz, na);
            end else begin
                it = chr(txt[i], (kind < 12) && ($urandom_range(0, 5) == 0),
                         MAXC_W'($urandom_range(0, 65535)), SIZE_W'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
            end
            send_char(it, 1'b0, '0);
            items_sent++;
        end
        if ($urandom_range(0, 9) < 3) begin
            nd = $urandom_range(1, 2);
            repeat (nd)
                send_char(chr(CHAR_W'($urandom_range(0, 255)), 1'b0,
                              MAXC_W'($urandom_range(0, 65535)), SIZE_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1))), 1'b0, '0);
        end
    endtask

    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        int next_drain;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.char_code  <= '0;
        in_ch.start_req  <= 1'b0;
        in_ch.max_chars  <= '0;
        in_ch.value_size <= SIZE_16;
        in_ch.skip_store <= 1'b0;

        dir_tab = '{
            // idle, no start: ignored
            row_typed(chr("A", 1'b0, '0, SIZE_16, 1'b0), res(1'b0, 1'b0, 1'b0, '0)),
            // zero limit
            row_typed(chr("5", 1'b1, '0, SIZE_16, 1'b0), res(1'b0, 1'b1, 1'b0, '0)),
            row_pred(chr(CH_PLUS, 1'b1, 16'hFFFF, SIZE_64, 1'b0)),
            row_pred(next_chr(CH_0)),
            row_pred(next_chr(CH_X_LO)),
            row_pred(next_chr("F")),
            row_pred(next_chr("f")),
            row_pred(next_chr(8'h00)),
            // limit reached on last digit, store suppressed
            row_pred(chr(CH_MINUS, 1'b1, 16'd3, SIZE_32, 1'b1)),
            row_pred(next_chr("1")),
            row_pred(next_chr("a")),
            // no digits at all
            row_typed(chr(CH_X_UP, 1'b1, 16'd5, SIZE_16, 1'b0), res(1'b0, 1'b1, 1'b0, '0)),
            row_pred(chr("7", 1'b1, 16'd20, SIZE_16, 1'b0)),
            row_pred(next_chr("F")),
            row_pred(next_chr("F")),
            row_pred(next_chr("F")),
            // 16-bit overflow saturates to all ones
            row_typed(next_chr(CH_0), res(1'b1, 1'b1, 1'b1, {VALUE_W{1'b1}})),
            // size code 3, "0X" then a non-digit
            row_pred(chr(CH_0, 1'b1, 16'd4, SIZE_CODE_3, 1'b0)),
            row_pred(next_chr(CH_X_UP)),
            row_typed(next_chr("g"), res(1'b0, 1'b1, 1'b1, '0)),
            // start while busy drops the running conversion
            row_pred(chr(CH_MINUS, 1'b1, 16'd100, SIZE_64, 1'b0)),
            row_pred(next_chr("8")),
            row_pred(chr("1", 1'b1, 16'hFFFF, SIZE_32, 1'b0)),
            row_pred(next_chr(8'hFF)),
            row_typed(chr("1", 1'b0, 16'hFFFF, SIZE_32, 1'b1), res(1'b0, 1'b0, 1'b0, '0))
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_char(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        wait_drained();

        items_sent = 0;
        next_drain = DRAIN_EVERY;
        while (items_sent < RAND_ITEMS) begin
            no_idle = ($urandom_range(0, 7) == 0);
            run_conversion();
            if (items_sent >= next_drain) begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("hex_text_to_integer_top_tb: PASS");
        end else begin
            $display("hex_text_to_integer_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("hex_text_to_integer_top_tb: FAIL");
        $finish;
    end

endmodule
